FILE: hw/rtl/assert_macros.svh
// assertion macros used by the rtl back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds -> prop holds in the same cycle
`define RLF_ASSERT_IMPLY(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (prop)) \
        else $error("assertion failed");

// cond holds -> prop holds in the next cycle
`define RLF_ASSERT_NEXT(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/rlf_pkg.sv
// shared types and constants of the running line fit unit
package rlf_pkg;

    // fixed widths of the running sums and fields
    localparam int CNT_W   = 16;
    localparam int SX_W    = 32;
    localparam int SY_W    = 40;
    localparam int SXX_W   = 48;
    localparam int SXY_W   = 64;
    localparam int SYY_W   = 64;
    localparam int MIN_W   = 16;
    localparam int DMAX_W  = 24;
    localparam int TMAX_W  = 24;
    localparam int SLOPE_W = 32;
    localparam int ICP_W   = 40;
    localparam int R2_W    = 21;

    localparam logic [MIN_W-1:0] MIN_DIST_RST = 16'd50;

    // intermediate magnitudes
    localparam int D_W    = 64;
    localparam int NXY_W  = 80;
    localparam int NYY_W  = 80;
    localparam int ICPM_W = 96;
    localparam int TMP_W  = 160;

    // shared multiplier: 32x32 limbs, up to three limbs per operand
    localparam int LIMB_W    = 32;
    localparam int MUL_LIMBS = 3;
    localparam int MUL_W     = LIMB_W * MUL_LIMBS;
    localparam int PROD_W    = 2 * MUL_W;

    // shared divider
    localparam int DIV_NW = 184;
    localparam int DIV_DW = 146;
    localparam int QUO_W  = 40;
    localparam int LOW_W  = 64;

    localparam logic [22:0]     SLOPE_SCALE = 23'd6553600;
    localparam logic [5:0]      SLOPE_QB    = 6'd32;
    localparam logic [5:0]      ICP_QB      = 6'd40;
    localparam logic [5:0]      R2_QB       = 6'd21;
    localparam logic [R2_W-1:0] R2_ONE      = 21'd1048576;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_BAD  = 2'd1;
    localparam status_t ST_FULL = 2'd2;

    typedef struct packed {
        status_t             status;
        logic [CNT_W-1:0]    count;
        logic [SX_W-1:0]     sx;
        logic [SY_W-1:0]     sy;
        logic [SXX_W-1:0]    sxx;
        logic [SXY_W-1:0]    sxy;
        logic [SYY_W-1:0]    syy;
    } snap_t;

    typedef struct packed {
        status_t             status;
        logic [CNT_W-1:0]    count;
        logic                fit_valid;
        logic [SLOPE_W-1:0]  slope;
        logic [ICP_W-1:0]    intercept;
        logic [R2_W-1:0]     r2;
    } res_t;

    typedef struct packed {
        logic       start;
        logic [1:0] la;
        logic [1:0] lb;
    } mul_req_t;

    typedef struct packed {
        logic       start;
        logic [5:0] qbits;
    } div_req_t;

endpackage

FILE: hw/rtl/rlf_fifo.sv
// small register queue
module rlf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             wr_en;
    logic             rd_en;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/rlf_front.sv
// front end: takes points, classifies them and keeps the running sums
module rlf_front #(
    parameter int DIST_WIDTH  = 16,
    parameter int TICK_WIDTH  = 24,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [DIST_WIDTH-1:0]         distance,
    input  logic signed [TICK_WIDTH-1:0]  ticks,
    input  logic                          cfg_we,
    input  logic [rlf_pkg::MIN_W-1:0]     cfg_wdata,
    input  logic                          snap_full,
    output logic                          snap_push,
    output rlf_pkg::snap_t                snap_data
);
    import rlf_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_ADD} state_t;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'((32'd1 << COUNT_WIDTH) - 32'd1);

    state_t               state_reg;
    logic [MIN_W-1:0]     min_reg;
    logic [DMAX_W-1:0]    d_reg;
    logic [TMAX_W-1:0]    t_reg;
    status_t              status_reg;
    logic [2*DMAX_W-1:0]  dd_reg;
    logic [2*DMAX_W-1:0]  dt_reg;
    logic [2*TMAX_W-1:0]  tt_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SX_W-1:0]      sx_reg;
    logic [SY_W-1:0]      sy_reg;
    logic [SXX_W-1:0]     sxx_reg;
    logic [SXY_W-1:0]     sxy_reg;
    logic [SYY_W-1:0]     syy_reg;

    logic                 accept;
    logic [DMAX_W-1:0]    d_in;
    logic                 t_pos;
    snap_t                snap_next;

    assign full   = (state_reg != F_IDLE) || snap_full;
    assign accept = push && !full;
    assign d_in   = DMAX_W'(distance);
    assign t_pos  = !ticks[TICK_WIDTH-1] && (ticks != '0);

    // sums after the point in flight, unchanged for a rejected point
    always_comb
    begin
        snap_next.status = status_reg;
        snap_next.count  = cnt_reg;
        snap_next.sx     = sx_reg;
        snap_next.sy     = sy_reg;
        snap_next.sxx    = sxx_reg;
        snap_next.sxy    = sxy_reg;
        snap_next.syy    = syy_reg;
        if (status_reg == ST_OK)
        begin
            snap_next.count = cnt_reg + 1'b1;
            snap_next.sx    = sx_reg + SX_W'(d_reg);
            snap_next.sy    = sy_reg + SY_W'(t_reg);
            snap_next.sxx   = sxx_reg + SXX_W'(dd_reg);
            snap_next.sxy   = sxy_reg + SXY_W'(dt_reg);
            snap_next.syy   = syy_reg + SYY_W'(tt_reg);
        end
    end

    assign snap_push = (state_reg == F_ADD);
    assign snap_data = snap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            min_reg    <= MIN_DIST_RST;
            status_reg <= ST_OK;
            cnt_reg    <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sxx_reg    <= '0;
            sxy_reg    <= '0;
            syy_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                min_reg <= cfg_wdata;
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        d_reg <= d_in;
                        t_reg <= TMAX_W'($unsigned(ticks));
                        priority if ((d_in <= DMAX_W'(min_reg)) || !t_pos)
                        begin
                            status_reg <= ST_BAD;
                        end
                        else if (cnt_reg >= CNT_MAX)
                        begin
                            status_reg <= ST_FULL;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                        end
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    dd_reg    <= d_reg * d_reg;
                    dt_reg    <= d_reg * t_reg;
                    tt_reg    <= t_reg * t_reg;
                    state_reg <= F_ADD;
                end
                F_ADD:
                begin
                    cnt_reg   <= snap_next.count;
                    sx_reg    <= snap_next.sx;
                    sy_reg    <= snap_next.sy;
                    sxx_reg   <= snap_next.sxx;
                    sxy_reg   <= snap_next.sxy;
                    syy_reg   <= snap_next.syy;
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/rlf_mul.sv
// multi-limb multiplier, one 32x32 partial product per cycle
module rlf_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rlf_pkg::mul_req_t            req,
    input  logic [rlf_pkg::MUL_W-1:0]    a,
    input  logic [rlf_pkg::MUL_W-1:0]    b,
    output logic                         done,
    output logic [rlf_pkg::PROD_W-1:0]   product
);
    import rlf_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_LAST} state_t;

    state_t                               state_reg;
    logic [1:0]                           i_reg;
    logic [1:0]                           j_reg;
    logic [1:0]                           la_reg;
    logic [1:0]                           lb_reg;
    logic [2*LIMB_W-1:0]                  pp_reg;
    logic [2:0]                           sh_reg;
    logic                                 pp_vld_reg;
    logic [PROD_W-1:0]                    acc_reg;
    logic                                 done_reg;

    logic [MUL_LIMBS-1:0][LIMB_W-1:0]     a_l;
    logic [MUL_LIMBS-1:0][LIMB_W-1:0]     b_l;
    logic [PROD_W-1:0]                    addend;

    assign a_l     = a;
    assign b_l     = b;
    assign addend  = PROD_W'(pp_reg) << (LIMB_W * sh_reg);
    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= M_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            la_reg     <= 2'd1;
            lb_reg     <= 2'd1;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
            if (pp_vld_reg)
            begin
                acc_reg <= acc_reg + addend;
            end
            unique case (state_reg)
                M_IDLE:
                begin
                    if (req.start)
                    begin
                        acc_reg   <= '0;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        la_reg    <= req.la;
                        lb_reg    <= req.lb;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    pp_reg     <= a_l[i_reg] * b_l[j_reg];
                    sh_reg     <= 3'(i_reg) + 3'(j_reg);
                    pp_vld_reg <= 1'b1;
                    if (j_reg == lb_reg - 2'd1)
                    begin
                        j_reg <= '0;
                        if (i_reg == la_reg - 2'd1)
                        begin
                            state_reg <= M_LAST;
                        end
                        else
                        begin
                            i_reg <= i_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 2'd1;
                    end
                end
                M_LAST:
                begin
                    // last partial product lands in the accumulator this edge
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/rlf_div.sv
// restoring divider, one quotient bit per cycle, with overflow check
module rlf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rlf_pkg::div_req_t             req,
    input  logic [rlf_pkg::DIV_NW-1:0]    num,
    input  logic [rlf_pkg::DIV_DW-1:0]    den,
    output logic                          done,
    output logic [rlf_pkg::QUO_W-1:0]     quotient,
    output logic                          ovf
);
    import rlf_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} state_t;

    state_t               state_reg;
    logic [5:0]           cnt_reg;
    logic [DIV_DW-1:0]    rem_reg;
    logic [LOW_W-1:0]     low_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic                 ovf_reg;
    logic                 done_reg;

    logic [DIV_NW-1:0]    hi;
    logic [DIV_DW:0]      trial;
    logic                 ge;

    assign hi       = num >> cnt_reg;
    assign trial    = {rem_reg, low_reg[LOW_W-1]};
    assign ge       = (trial >= {1'b0, den});
    assign done     = done_reg;
    assign quotient = quo_reg;
    assign ovf      = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        cnt_reg   <= req.qbits;
                        state_reg <= D_CHECK;
                    end
                end
                D_CHECK:
                begin
                    // quotient does not fit in cnt_reg bits
                    ovf_reg   <= (hi >= DIV_NW'(den));
                    rem_reg   <= hi[DIV_DW-1:0];
                    low_reg   <= num[LOW_W-1:0] << (7'(LOW_W) - {1'b0, cnt_reg});
                    quo_reg   <= '0;
                    state_reg <= D_RUN;
                end
                D_RUN:
                begin
                    rem_reg <= ge ? DIV_DW'(trial - {1'b0, den}) : trial[DIV_DW-1:0];
                    quo_reg <= {quo_reg[QUO_W-2:0], ge};
                    low_reg <= low_reg << 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/rlf_back.sv
// back end: computes the fit from one snapshot of the sums
`include "assert_macros.svh"

module rlf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              snap_empty,
    input  rlf_pkg::snap_t    snap_data,
    output logic              snap_pop,
    input  logic              out_full,
    output logic              out_push,
    output rlf_pkg::res_t     out_data
);
    import rlf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
        S_DS, S_DI, S_P10, S_P11, S_DR, S_OUT
    } state_t;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } diff_t;

    function automatic diff_t diff_fn(input logic [PROD_W-1:0] x, input logic [PROD_W-1:0] y);
        diff_t r;
        if (x >= y)
        begin
            r.neg = 1'b0;
            r.mag = x - y;
        end
        else
        begin
            r.neg = 1'b1;
            r.mag = y - x;
        end
        return r;
    endfunction

    // clamp a rounded magnitude into a signed field of the given width
    function automatic logic [ICP_W-1:0] sat_fn(input logic [QUO_W-1:0] q, input logic over,
                                                input logic neg, input logic [5:0] bits);
        logic [QUO_W:0] lim;
        logic [QUO_W:0] mag;
        logic [QUO_W:0] res;
        lim = (QUO_W+1)'(1) << (bits - 6'd1);
        mag = {1'b0, q};
        if (neg)
        begin
            if (over || (mag > lim))
            begin
                mag = lim;
            end
            res = '0 - mag;
        end
        else
        begin
            if (over || (mag > lim - 1'b1))
            begin
                mag = lim - 1'b1;
            end
            res = mag;
        end
        return res[ICP_W-1:0];
    endfunction

    state_t               state_reg;
    snap_t                snap_reg;
    logic [TMP_W-1:0]     tmp_reg;
    logic [D_W-1:0]       d_mag_reg;
    logic                 d_neg_reg;
    logic [NXY_W-1:0]     nxy_reg;
    logic                 nxy_neg_reg;
    logic [NYY_W-1:0]     nyy_reg;
    logic                 nyy_neg_reg;
    logic [ICPM_W-1:0]    icp_reg;
    logic                 icp_neg_reg;
    logic                 fit_reg;
    logic [SLOPE_W-1:0]   slope_reg;
    logic [ICP_W-1:0]     icp_out_reg;
    logic [R2_W-1:0]      r2_reg;
    mul_req_t             mul_req_reg;
    logic [MUL_W-1:0]     mul_a_reg;
    logic [MUL_W-1:0]     mul_b_reg;
    div_req_t             div_req_reg;
    logic [DIV_NW-1:0]    div_num_reg;
    logic [DIV_DW-1:0]    div_den_reg;

    logic                 mul_done;
    logic [PROD_W-1:0]    prod;
    logic                 div_done;
    logic [QUO_W-1:0]     quo;
    logic                 quo_ovf;
    diff_t                dres;
    logic [ICP_W-1:0]     slope_sat;
    logic [ICP_W-1:0]     icp_sat;

    rlf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .product (prod)
    );

    rlf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req_reg),
        .num      (div_num_reg),
        .den      (div_den_reg),
        .done     (div_done),
        .quotient (quo),
        .ovf      (quo_ovf)
    );

    assign dres      = diff_fn(PROD_W'(tmp_reg), prod);
    assign slope_sat = sat_fn(quo, quo_ovf, nxy_neg_reg ^ d_neg_reg, SLOPE_QB);
    assign icp_sat   = sat_fn(quo, quo_ovf, icp_neg_reg ^ d_neg_reg, ICP_QB);

    assign snap_pop  = (state_reg == S_IDLE) && !snap_empty;
    assign out_push  = (state_reg == S_OUT) && !out_full;

    always_comb
    begin
        out_data.status    = snap_reg.status;
        out_data.count     = snap_reg.count;
        out_data.fit_valid = fit_reg;
        out_data.slope     = slope_reg;
        out_data.intercept = icp_out_reg;
        out_data.r2        = r2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mul_req_reg <= '0;
            div_req_reg <= '0;
            fit_reg     <= 1'b0;
            slope_reg   <= '0;
            icp_out_reg <= '0;
            r2_reg      <= '0;
        end
        else
        begin
            mul_req_reg.start <= 1'b0;
            div_req_reg.start <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!snap_empty)
                    begin
                        snap_reg    <= snap_data;
                        fit_reg     <= 1'b0;
                        slope_reg   <= '0;
                        icp_out_reg <= '0;
                        r2_reg      <= '0;
                        if (snap_data.count >= CNT_W'(2))
                        begin
                            // n * sxx
                            mul_req_reg <= '{start: 1'b1, la: 2'd1, lb: 2'd2};
                            mul_a_reg   <= MUL_W'(snap_data.count);
                            mul_b_reg   <= MUL_W'(snap_data.sxx);
                            state_reg   <= S_P1;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_P1:
                begin
                    if (mul_done)
                    begin
                        tmp_reg     <= prod[TMP_W-1:0];
                        mul_req_reg <= '{start: 1'b1, la: 2'd1, lb: 2'd1};
                        mul_a_reg   <= MUL_W'(snap_reg.sx);
                        mul_b_reg   <= MUL_W'(snap_reg.sx);
                        state_reg   <= S_P2;
                    end
                end
                S_P2:
                begin
                    if (mul_done)
                    begin
                        // denominator n*sxx - sx^2
                        d_mag_reg <= dres.mag[D_W-1:0];
                        d_neg_reg <= dres.neg;
                        if (dres.mag == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            mul_req_reg <= '{start: 1'b1, la: 2'd1, lb: 2'd2};
                            mul_a_reg   <= MUL_W'(snap_reg.count);
                            mul_b_reg   <= MUL_W'(snap_reg.sxy);
                            state_reg   <= S_P3;
                        end
                    end
                end
                S_P3:
                begin
                    if (mul_done)
                    begin
                        tmp_reg     <= prod[TMP_W-1:0];
                        mul_req_reg <= '{start: 1'b1, la: 2'd1, lb: 2'd2};
                        mul_a_reg   <= MUL_W'(snap_reg.sx);
                        mul_b_reg   <= MUL_W'(snap_reg.sy);
                        state_reg   <= S_P4;
                    end
                end
                S_P4:
                begin
                    if (mul_done)
                    begin
                        nxy_reg     <= dres.mag[NXY_W-1:0];
                        nxy_neg_reg <= dres.neg;
                        mul_req_reg <= '{start: 1'b1, la: 2'd1, lb: 2'd2};
                        mul_a_reg   <= MUL_W'(snap_reg.count);
                        mul_b_reg   <= MUL_W'(snap_reg.syy);
                        state_reg   <= S_P5;
                    end
                end
                S_P5:
                begin
                    if (mul_done)
                    begin
                        tmp_reg     <= prod[TMP_W-1:0];
                        mul_req_reg <= '{start: 1'b1, la: 2'd2, lb: 2'd2};
                        mul_a_reg   <= MUL_W'(snap_reg.sy);
                        mul_b_reg   <= MUL_W'(snap_reg.sy);
                        state_reg   <= S_P6;
                    end
                end
                S_P6:
                begin
                    if (mul_done)
                    begin
                        nyy_reg     <= dres.mag[NYY_W-1:0];
                        nyy_neg_reg <= dres.neg;
                        mul_req_reg <= '{start: 1'b1, la: 2'd2, lb: 2'd2};
                        mul_a_reg   <= MUL_W'(snap_reg.sy);
                        mul_b_reg   <= MUL_W'(snap_reg.sxx);
                        state_reg   <= S_P7;
                    end
                end
                S_P7:
                begin
                    if (mul_done)
                    begin
                        tmp_reg     <= prod[TMP_W-1:0];
                        mul_req_reg <= '{start: 1'b1, la: 2'd1, lb: 2'd2};
                        mul_a_reg   <= MUL_W'(snap_reg.sx);
                        mul_b_reg   <= MUL_W'(snap_reg.sxy);
                        state_reg   <= S_P8;
                    end
                end
                S_P8:
                begin
                    if (mul_done)
                    begin
                        // intercept numerator sy*sxx - sx*sxy
                        icp_reg     <= dres.mag[ICPM_W-1:0];
                        icp_neg_reg <= dres.neg;
                        fit_reg     <= 1'b1;
                        mul_req_reg <= '{start: 1'b1, la: 2'd3, lb: 2'd1};
                        mul_a_reg   <= MUL_W'(nxy_reg);
                        mul_b_reg   <= MUL_W'(SLOPE_SCALE);
                        state_reg   <= S_P9;
                    end
                end
                S_P9:
                begin
                    if (mul_done)
                    begin
                        // round to nearest: (2*num + den) / (2*den)
                        div_num_reg <= (DIV_NW'(prod) << 1) + DIV_NW'(d_mag_reg);
                        div_den_reg <= DIV_DW'(d_mag_reg) << 1;
                        div_req_reg <= '{start: 1'b1, qbits: SLOPE_QB};
                        state_reg   <= S_DS;
                    end
                end
                S_DS:
                begin
                    if (div_done)
                    begin
                        slope_reg   <= slope_sat[SLOPE_W-1:0];
                        // icp * 256, doubled for rounding
                        div_num_reg <= (DIV_NW'(icp_reg) << 9) + DIV_NW'(d_mag_reg);
                        div_req_reg <= '{start: 1'b1, qbits: ICP_QB};
                        state_reg   <= S_DI;
                    end
                end
                S_DI:
                begin
                    if (div_done)
                    begin
                        icp_out_reg <= icp_sat;
                        if (!d_neg_reg && !nyy_neg_reg && (nyy_reg != '0))
                        begin
                            mul_req_reg <= '{start: 1'b1, la: 2'd3, lb: 2'd3};
                            mul_a_reg   <= MUL_W'(nxy_reg);
                            mul_b_reg   <= MUL_W'(nxy_reg);
                            state_reg   <= S_P10;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_P10:
                begin
                    if (mul_done)
                    begin
                        tmp_reg     <= prod[TMP_W-1:0];
                        mul_req_reg <= '{start: 1'b1, la: 2'd2, lb: 2'd3};
                        mul_a_reg   <= MUL_W'(d_mag_reg);
                        mul_b_reg   <= MUL_W'(nyy_reg);
                        state_reg   <= S_P11;
                    end
                end
                S_P11:
                begin
                    if (mul_done)
                    begin
                        // nxy^2 * 2^20, doubled for rounding, over den * nyy
                        div_num_reg <= (DIV_NW'(tmp_reg) << 21) + DIV_NW'(prod);
                        div_den_reg <= DIV_DW'(prod) << 1;
                        div_req_reg <= '{start: 1'b1, qbits: R2_QB};
                        state_reg   <= S_DR;
                    end
                end
                S_DR:
                begin
                    if (div_done)
                    begin
                        r2_reg    <= (quo_ovf || (quo > QUO_W'(R2_ONE))) ? R2_ONE
                                                                         : quo[R2_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `RLF_ASSERT_IMPLY(a_push_room, clk, rst_n, out_push, !out_full)
    `RLF_ASSERT_IMPLY(a_no_fit_zero, clk, rst_n, out_push && !fit_reg, (slope_reg == '0) && (icp_out_reg == '0) && (r2_reg == '0))
    `RLF_ASSERT_IMPLY(a_r2_range, clk, rst_n, out_push, r2_reg <= R2_ONE)
    `RLF_ASSERT_NEXT(a_pop_busy, clk, rst_n, snap_pop, state_reg != S_IDLE)

endmodule

FILE: hw/rtl/running_line_fit_unit.sv
// top level of the running least-squares line fit unit
// a point passes the front-end states F_IDLE, F_MUL and F_ADD; the back end goes to output
// directly below two points, after the denominator when it is zero, else after the full fit
// throughput: one point per back-end pass, set by the shared 32x32 limb multiplier
// (eleven products, 37 partial products) and the bit-serial divider (32 + 40 + 21 bits)
// reset: asynchronous active-low rst_n clears the sums, empties the queues, min_distance 50
module running_line_fit_unit #(
    parameter int DIST_WIDTH  = 16,
    parameter int TICK_WIDTH  = 24,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input transaction
    input  logic                              push,
    output logic                              full,
    input  logic [DIST_WIDTH-1:0]             distance,
    input  logic signed [TICK_WIDTH-1:0]      ticks,
    // result transaction
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        status,
    output logic [rlf_pkg::CNT_W-1:0]         point_count,
    output logic                              fit_valid,
    output logic signed [rlf_pkg::SLOPE_W-1:0] slope,
    output logic signed [rlf_pkg::ICP_W-1:0]  intercept,
    output logic [rlf_pkg::R2_W-1:0]          r_squared,
    // min_distance register write
    input  logic                              cfg_we,
    input  logic [rlf_pkg::MIN_W-1:0]         cfg_wdata
);
    import rlf_pkg::*;

    // snapshot queue between front and back: each side stalls on its own
    localparam int SNAP_DEPTH = 2;
    localparam int RES_DEPTH  = 2;

    snap_t  snap_in;
    snap_t  snap_out;
    logic   snap_push;
    logic   snap_full;
    logic   snap_pop;
    logic   snap_empty;
    res_t   res_in;
    res_t   res_out;
    logic   res_push;
    logic   res_full;

    // front end: classify the point and update the running sums
    rlf_front #(
        .DIST_WIDTH  (DIST_WIDTH),
        .TICK_WIDTH  (TICK_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .distance  (distance),
        .ticks     (ticks),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .snap_full (snap_full),
        .snap_push (snap_push),
        .snap_data (snap_in)
    );

    rlf_fifo #(
        .WIDTH ($bits(snap_t)),
        .DEPTH (SNAP_DEPTH)
    ) u_snap_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (snap_push),
        .wdata (snap_in),
        .full  (snap_full),
        .pop   (snap_pop),
        .rdata (snap_out),
        .empty (snap_empty)
    );

    // back end: products, differences and rounded quotients of the fit
    rlf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_empty (snap_empty),
        .snap_data  (snap_out),
        .snap_pop   (snap_pop),
        .out_full   (res_full),
        .out_push   (res_push),
        .out_data   (res_in)
    );

    // result queue: the oldest result sits on the ports while empty is low
    rlf_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign status      = res_out.status;
    assign point_count = res_out.count;
    assign fit_valid   = res_out.fit_valid;
    assign slope       = res_out.slope;
    assign intercept   = res_out.intercept;
    assign r_squared   = res_out.r2;

endmodule
